// File: rtl/hck_pkg.sv
// Package for the Hunt-Crossley contact force block: constants, register codes
// and the elaboration-time square-root table of the exp2 stages.
// No dependencies.
package hck_pkg;

  // fraction bits of the log2 result, one pipeline stage per bit
  localparam int LogFrac = 24;
  // stage counts of each unit
  localparam int LogLat  = LogFrac + 1;       // normalize + squaring stages
  localparam int ExpLat  = LogFrac + 2;       // scale + product stages + shift
  localparam int FrcLat  = 4;                 // split multiply, sums, saturate
  localparam int SideLat = LogLat + ExpLat;   // input stage to force unit entry
  localparam int TotLat  = 1 + SideLat + FrcLat;

  localparam logic [47:0] FMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FMin = 48'h8000_0000_0000;
  localparam logic [62:0] XMax = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    RegStiff = 2'd0,
    RegDiss  = 2'd1,
    RegShape = 2'd2
  } cfg_reg_e;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-i) in Q1.30, each one the floor root of the previous
  function automatic logic [31:0] exp_root(input int i);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 1; k <= LogFrac; k++) begin
      if (k <= i) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

// File: rtl/hck_log2.sv
// log2 unit: leading-one normalize, then one mantissa squaring per stage.
// Uses hck_pkg.
module hck_log2 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] c_i,
  output logic [4:0]  e_o,
  output logic [hck_pkg::LogFrac-1:0] fr_o
);

  localparam int NF = hck_pkg::LogFrac;

  logic [4:0]    e_q  [NF+1];
  logic [31:0]   m_q  [NF+1];
  logic [NF-1:0] fr_q [NF+1];
  logic [4:0]    lead;

  // leading one position (zero input gives 0, overridden later)
  always_comb begin
    lead = '0;
    for (int k = 1; k < 32; k++) begin
      if (c_i[k]) lead = 5'(k);
    end
  end

  // normalize stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0]  <= lead;
      m_q[0]  <= c_i << (5'd31 - lead);
      fr_q[0] <= '0;
    end
  end

  // one fraction bit per stage
  for (genvar k = 0; k < NF; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_q[k]) * 64'(m_q[k]);
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[k+1]  <= e_q[k];
        m_q[k+1]  <= t[32] ? t[32:1] : t[31:0];
        fr_q[k+1] <= {fr_q[k][NF-2:0], t[32]};
      end
    end
  end

  assign e_o  = e_q[NF];
  assign fr_o = fr_q[NF];

endmodule

// File: rtl/hck_exp2.sv
// Exponent unit: scales log2 by shape, builds 2^frac from a product of
// constant roots (one per stage), then shifts into Q.16 with rounding.
// Uses hck_pkg.
module hck_exp2 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [4:0]  e_i,
  input  logic [hck_pkg::LogFrac-1:0] fr_i,
  input  logic [15:0] shape_i,
  output logic [62:0] x_o
);

  localparam int NF = hck_pkg::LogFrac;

  logic signed [28:0] lg;
  logic signed [45:0] yprod;
  logic signed [9:0]  n_q [NF+1];
  logic [NF-1:0]      f_q [NF+1];
  logic [30:0]        p_q [NF+1];
  logic [62:0]        x_d;
  logic [62:0]        x_q;
  logic [5:0]         lsh;
  logic [5:0]         rsh;
  logic [63:0]        pw;

  // y = floor(shape * log2 / 2^12)
  assign lg    = $signed({e_i - 5'd16, fr_i});
  assign yprod = $signed({1'b0, shape_i}) * lg;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= yprod[45:36];
      f_q[0] <= yprod[35:12];
      p_q[0] <= 31'd1 << 30;
    end
  end

  // multiply in the root for each set fraction bit
  for (genvar k = 0; k < NF; k++) begin : g_mul
    localparam logic [31:0] Root = hck_pkg::exp_root(k + 1);
    logic [62:0] pr;
    assign pr = 63'(p_q[k]) * 63'(Root);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1] <= n_q[k];
        f_q[k+1] <= f_q[k];
        p_q[k+1] <= f_q[k][NF-1-k] ? pr[60:30] : p_q[k];
      end
    end
  end

  // place the integer exponent
  assign pw  = {33'd0, p_q[NF]};
  assign lsh = 6'(n_q[NF] - 10'sd14);
  assign rsh = 6'(10'sd14 - n_q[NF]);
  always_comb begin
    if (n_q[NF] >= 10'sd47) begin
      x_d = hck_pkg::XMax;
    end else if (n_q[NF] >= 10'sd14) begin
      x_d = 63'(pw << lsh);
    end else if (n_q[NF] < -10'sd26) begin
      x_d = '0;
    end else begin
      x_d = 63'((pw + (64'd1 << (rsh - 6'd1))) >> rsh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) x_q <= x_d;
  end

  assign x_o = x_q;

endmodule

// File: rtl/hck_force.sv
// Force unit: x times G split in partial products over stages, then floor
// divide by 2^16, saturate to 48 bits and form the opposite force.
// Uses hck_pkg.
module hck_force (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [62:0]        x_i,
  input  logic signed [50:0] g_i,
  input  logic               contact_i,
  output logic [47:0]        force_a_o,
  output logic [47:0]        force_b_o,
  output logic               contact_o
);

  logic [50:0]  gabs;
  logic [56:0]  pp_ll_q, pp_lh_q;
  logic [55:0]  pp_hl_q, pp_hh_q;
  logic [88:0]  sl_q, sh_q;
  logic [113:0] prod_q;
  logic [2:0]   neg_q;
  logic [2:0]   ct_q;
  logic [97:0]  qp, qn;
  logic [47:0]  fb, fa;
  logic [47:0]  fa_q, fb_q;
  logic         ct_out_q;

  assign gabs = g_i[50] ? 51'(-g_i) : 51'(g_i);

  // stage 1: partial products, stage 2: pair sums, stage 3: full product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= 57'(x_i[31:0])  * 57'(gabs[24:0]);
      pp_hl_q <= 56'(x_i[62:32]) * 56'(gabs[24:0]);
      pp_lh_q <= 57'(x_i[31:0])  * 57'(gabs[49:25]);
      pp_hh_q <= 56'(x_i[62:32]) * 56'(gabs[49:25]);
      sl_q    <= 89'(pp_ll_q) + (89'(pp_hl_q) << 32);
      sh_q    <= 89'(pp_lh_q) + (89'(pp_hh_q) << 32);
      prod_q  <= 114'(sl_q) + (114'(sh_q) << 25);
      neg_q   <= {neg_q[1:0], g_i[50]};
      ct_q    <= {ct_q[1:0], contact_i};
    end
  end

  // floor divide with saturation
  assign qp = 98'(prod_q >> 16);
  assign qn = 98'((prod_q + 114'hFFFF) >> 16);
  always_comb begin
    if (neg_q[2]) begin
      fb = (qn > (98'd1 << 47)) ? hck_pkg::FMin : 48'(-qn[47:0]);
    end else begin
      fb = (qp > 98'(hck_pkg::FMax)) ? hck_pkg::FMax : qp[47:0];
    end
    fa = (fb == hck_pkg::FMin) ? hck_pkg::FMax : 48'(-fb);
  end

  // stage 4: output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q     <= fa;
      fb_q     <= fb;
      ct_out_q <= ct_q[2];
    end
  end

  assign force_a_o = fa_q;
  assign force_b_o = fb_q;
  assign contact_o = ct_out_q;

endmodule

// File: rtl/hunt_crossley_impact_force.sv
// Top level of the Hunt-Crossley contact force pipeline.
// Uses hck_pkg, hck_log2, hck_exp2, hck_force.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid_i/tready_o      pos_a, vel_a, pos_b, vel_b
//  m_axis    out  m_axis_tvalid_o/tready_i      force_a, force_b; in_contact
//  cfg       in   cfg_we_i                      stiffness, dissipation, shape
//
// One word per cycle while the output is not stalled; the pipeline is hck_pkg::TotLat
// stages deep, most of them the 24 squaring stages of the log2 unit and the 24 root stages of the exp2 unit.
// Reset clears the valid bits and the config registers to zero.
// A stalled output word freezes the whole pipeline; nothing is dropped.
module hunt_crossley_impact_force (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // pos_a, vel_a, pos_b, vel_b
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,   // force_a, force_b
  output logic         m_axis_tuser_o,   // in_contact
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int SL = hck_pkg::SideLat;
  localparam int TL = hck_pkg::TotLat;

  logic [31:0] stiff_q, diss_q;
  logic [15:0] shape_q;
  logic        en;
  logic        vld_q [TL];

  logic [31:0]        c_q;
  logic signed [32:0] dv_q;
  logic signed [65:0] dprod_q;
  logic signed [50:0] gd_q [SL-1];
  logic               ct_q [SL+1];
  logic               cz_q [SL+1];

  logic [4:0]  lg_e;
  logic [hck_pkg::LogFrac-1:0] lg_fr;
  logic [62:0] x_exp, x_sel;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= '0;
      diss_q  <= '0;
      shape_q <= '0;
    end else if (cfg_we_i) begin
      unique case (hck_pkg::cfg_reg_e'(cfg_idx_i))
        hck_pkg::RegStiff: stiff_q <= cfg_data_i;
        hck_pkg::RegDiss:  diss_q  <= cfg_data_i;
        hck_pkg::RegShape: shape_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // global advance: output empty or being taken
  assign en              = !vld_q[TL-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[TL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TL; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < TL; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // input stage, damping product, G, and side delay lines
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q      <= s_axis_tdata_i[31:0] - s_axis_tdata_i[95:64];
      dv_q     <= $signed({s_axis_tdata_i[63], s_axis_tdata_i[63:32]})
                - $signed({s_axis_tdata_i[127], s_axis_tdata_i[127:96]});
      ct_q[0]  <= $signed(s_axis_tdata_i[31:0]) >= $signed(s_axis_tdata_i[95:64]);
      cz_q[0]  <= s_axis_tdata_i[31:0] == s_axis_tdata_i[95:64];
      dprod_q  <= $signed({1'b0, diss_q}) * dv_q;
      gd_q[0]  <= $signed({11'd0, stiff_q, 8'd0})
                + $signed({dprod_q[65], dprod_q[65:16]});
      for (int k = 1; k < SL-1; k++) gd_q[k] <= gd_q[k-1];
      for (int k = 1; k <= SL; k++) begin
        ct_q[k] <= ct_q[k-1];
        cz_q[k] <= cz_q[k-1];
      end
    end
  end

  hck_log2 u_log (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (c_q),
    .e_o   (lg_e),
    .fr_o  (lg_fr)
  );

  hck_exp2 u_exp (
    .clk_i   (clk_i),
    .en_i    (en),
    .e_i     (lg_e),
    .fr_i    (lg_fr),
    .shape_i (shape_q),
    .x_o     (x_exp)
  );

  // no contact gives zero force; zero compression gives 0^shape
  always_comb begin
    if (!ct_q[SL]) begin
      x_sel = '0;
    end else if (cz_q[SL]) begin
      x_sel = (shape_q == 16'd0) ? 63'd65536 : 63'd0;
    end else begin
      x_sel = x_exp;
    end
  end

  hck_force u_frc (
    .clk_i     (clk_i),
    .en_i      (en),
    .x_i       (x_sel),
    .g_i       (gd_q[SL-2]),
    .contact_i (ct_q[SL]),
    .force_a_o (m_axis_tdata_o[47:0]),
    .force_b_o (m_axis_tdata_o[95:48]),
    .contact_o (m_axis_tuser_o)
  );

endmodule

// File: tb/hunt_crossley_impact_force_tb.sv
// Testbench for the Hunt-Crossley contact force pipeline: random bursty stream
// stimulus, random output stalls, a bit-exact fixed-point force predictor.
// Depends on hck_pkg and hunt_crossley_impact_force.
module hunt_crossley_impact_force_tb;

  typedef struct packed {
    logic signed [31:0] vel_b;
    logic signed [31:0] pos_b;
    logic signed [31:0] vel_a;
    logic signed [31:0] pos_a;
  } body_word_t;

  typedef struct {
    logic [47:0] force_a;
    logic [47:0] force_b;
    logic        in_contact;
  } force_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = hck_pkg::RegStiff;
  logic [31:0]  cfg_data_i = '0;

  hunt_crossley_impact_force dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [31:0] k_stiff;
  logic [31:0] k_diss;
  logic [15:0] k_shape;

  body_word_t  pending_q[$];
  force_word_t expected_q[$];
  int          errors = 0;
  int          accepted_in = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  // floor division by 2^s of a signed value
  function automatic longint floor_div2(longint v, int s);
    longint unsigned mag;
    if (v >= 0) return longint'(longint'(v) >>> s);
    mag = longint'(0) - v;
    mag = (mag + ((64'd1 << s) - 1)) >> s;
    return -longint'(mag);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2(c/2^16) in Q.24
  function automatic longint log2_compress(longint unsigned c);
    int e;
    longint unsigned m;
    longint fr;
    e = 31;
    fr = 0;
    while (e > 0 && c[e] == 1'b0) e--;
    m = c << (31 - e);
    for (int i = 0; i < hck_pkg::LogFrac; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr |= 1;
        m >>= 1;
      end
    end
    return longint'(e - 16) * (longint'(1) << hck_pkg::LogFrac) + fr;
  endfunction

  // 2^(y/2^24) in Q.16
  function automatic longint unsigned pow2_q16(longint y);
    longint n, s;
    longint unsigned f, p, r;
    n = floor_div2(y, hck_pkg::LogFrac);
    f = y - n * (longint'(1) << hck_pkg::LogFrac);
    p = 64'd1 << 30;
    r = 64'd2 << 30;
    for (int i = 1; i <= hck_pkg::LogFrac; i++) begin
      r = floor_root(r << 30);
      if (f[hck_pkg::LogFrac - i]) p = (p * r) >> 30;
    end
    if (n + 16 >= 63) return 64'h7FFF_FFFF_FFFF_FFFF;
    s = n + 16 - 30;
    if (s >= 0) return p << s;
    if (-s > 40) return 0;
    return (p + (64'd1 << (-s - 1))) >> (-s);
  endfunction

  function automatic force_word_t contact_force(body_word_t w);
    force_word_t o;
    longint pa, pb, dv, d, g, fb, fa;
    longint unsigned c, x, gm, m, q, xmax;
    xmax = 64'h7FFF_FFFF_FFFF_FFFF;
    pa = w.pos_a;
    pb = w.pos_b;
    if (pa < pb) begin
      o.force_a = '0;
      o.force_b = '0;
      o.in_contact = 1'b0;
      return o;
    end
    c = pa - pb;
    if (c == 0) x = (k_shape == 0) ? 64'd65536 : 64'd0;
    else x = pow2_q16(floor_div2(longint'(k_shape) * log2_compress(c), 12));
    dv = longint'(w.vel_a) - longint'(w.vel_b);
    // product can exceed 2^63, so shift it as an unsigned value
    if (dv >= 0) d = longint'((longint'(k_diss) * dv) >> 16);
    else d = -longint'((longint'(k_diss) * (-dv) + 64'hFFFF) >> 16);
    g = longint'(k_stiff) * 256 + d;
    if (g == 0 || x == 0) begin
      fb = 0;
    end else begin
      gm = (g > 0) ? g : -g;
      if (x > xmax / gm) begin
        fb = (g > 0) ? longint'(hck_pkg::FMax) : -longint'(64'h8000_0000_0000);
      end else begin
        m = x * gm;
        if (g > 0) begin
          q = m >> 16;
          fb = (q > 64'h7FFF_FFFF_FFFF) ? longint'(hck_pkg::FMax) : longint'(q);
        end else begin
          q = (m + 64'hFFFF) >> 16;
          fb = (q > 64'h8000_0000_0000) ? -longint'(64'h8000_0000_0000) : -longint'(q);
        end
      end
    end
    // negation of the most negative force saturates
    fa = (fb == -longint'(64'h8000_0000_0000)) ? longint'(hck_pkg::FMax) : -fb;
    o.force_a = fa[47:0];
    o.force_b = fb[47:0];
    o.in_contact = 1'b1;
    return o;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
      2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return 32'(signed'($urandom_range(8))) - 4;
    endcase
  endfunction

  function automatic body_word_t rand_word();
    body_word_t w;
    w.pos_a = rand_pos();
    w.pos_b = ($urandom_range(3) == 0) ? rand_pos() : w.pos_a - 32'($urandom_range(32'h30000));
    w.vel_a = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(32'h40000)) - 32'h20000;
    w.vel_b = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(32'h40000)) - 32'h20000;
    return w;
  endfunction

  function automatic body_word_t mk(logic [31:0] pa, logic [31:0] va,
                                    logic [31:0] pb, logic [31:0] vb);
    body_word_t w;
    w.pos_a = pa;
    w.vel_a = va;
    w.pos_b = pb;
    w.vel_b = vb;
    return w;
  endfunction

  task automatic write_reg(hck_pkg::cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hck_pkg::RegStiff: k_stiff = val;
      hck_pkg::RegDiss:  k_diss = val;
      default:           k_shape = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (hck_pkg::TotLat + 10) @(posedge clk_i);
  endtask

  task automatic setting(logic [31:0] ks, logic [31:0] kd, logic [15:0] al);
    drain();
    write_reg(hck_pkg::RegStiff, ks);
    write_reg(hck_pkg::RegDiss, kd);
    write_reg(hck_pkg::RegShape, {16'h0, al});
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      logic busy;
      busy = s_axis_tvalid_i && !s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(contact_force(pending_q.pop_front()));
        accepted_in++;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= pending_q[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(30);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern; hold_off forces a long stall
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 37;
      if (hold_off) m_axis_tready_i <= 1'b0;
      else if (stall_phase < 12) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ($urandom_range(3) != 0);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      force_word_t exp_w;
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
          || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h user %b", $time, m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          if (m_axis_tdata_o[47:0] !== exp_w.force_a) begin
            $display("%0t: force_a exp %h got %h", $time, exp_w.force_a, m_axis_tdata_o[47:0]);
            errors++;
          end
          if (m_axis_tdata_o[95:48] !== exp_w.force_b) begin
            $display("%0t: force_b exp %h got %h", $time, exp_w.force_b, m_axis_tdata_o[95:48]);
            errors++;
          end
          if (m_axis_tuser_o !== exp_w.in_contact) begin
            $display("%0t: in_contact exp %b got %b", $time, exp_w.in_contact, m_axis_tuser_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    k_stiff = '0;
    k_diss = '0;
    k_shape = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers, then linear contact, extremes of the fields
    pending_q.push_back(mk(32'h0001_0000, 0, 0, 0));
    setting(32'h0000_0100, 32'h0001_0000, 16'h1000);
    pending_q.push_back(mk(32'h0001_0000, 32'h0001_0000, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 0));                        // zero compression
    pending_q.push_back(mk(0, 0, 32'h0000_0001, 0));            // no contact
    pending_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 0));
    pending_q.push_back(mk(32'h0000_0001, 32'hFFFF_FFFF, 0, 32'h0000_0001));
    setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    pending_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(mk(32'h0000_0001, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 0));
    setting(0, 32'hFFFF_FFFF, 16'h0);
    pending_q.push_back(mk(0, 32'h8000_0000, 0, 32'h7FFF_FFFF));  // most negative force
    pending_q.push_back(mk(0, 0, 0, 0));
    pending_q.push_back(mk(32'h0002_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000));
    setting(0, 0, 16'h2000);
    pending_q.push_back(mk(32'h0003_0000, 32'h1234_5678, 0, 0));

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      setting((ph % 4 == 0) ? $urandom : $urandom_range(32'h0010_0000),
              (ph % 3 == 0) ? $urandom : $urandom_range(32'h0004_0000),
              (ph == 7) ? 16'hFFFF : 16'($urandom_range(16'h3000)));
      for (int i = 0; i < 50; i++) pending_q.push_back(rand_word());
      if (ph == 3) begin
        // long receiver hold-off while words keep coming
        while (pending_q.size() > 30) @(posedge clk_i);
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end

    drain();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/hck_pkg.sv
rtl/hck_log2.sv
rtl/hck_exp2.sv
rtl/hck_force.sv
rtl/hunt_crossley_impact_force.sv
tb/hunt_crossley_impact_force_tb.sv
